[rtl/itp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and operator tables shared by the infix to postfix
// converter modules.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam logic [7:0] CHAR_POW    = 8'h5E;
  localparam logic [7:0] CHAR_MUL    = 8'h2A;
  localparam logic [7:0] CHAR_DIV    = 8'h2F;
  localparam logic [7:0] CHAR_ADD    = 8'h2B;
  localparam logic [7:0] CHAR_SUB    = 8'h2D;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;

  localparam logic [2:0] OP_LPAREN = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_POW    = 3'd5;

  localparam int unsigned NUM_LETTERS = 26;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RP_READ,
    ST_RP_EVAL,
    ST_OP_READ,
    ST_OP_EVAL,
    ST_FL_READ,
    ST_FL_EVAL,
    ST_MARKER,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OP,
    CLS_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_CHAR,
    EMIT_TOP,
    EMIT_MARKER
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    emit_sel_t emit;
    logic      set_err;
    logic      clear;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        is_end;
    logic        stack_empty;
    logic        top_lparen;
    logic        top_pops;
    logic        slot_ok;
  } sts_t;

  function automatic logic [2:0] op_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      CHAR_ADD: code = OP_ADD;
      CHAR_SUB: code = OP_SUB;
      CHAR_MUL: code = OP_MUL;
      CHAR_DIV: code = OP_DIV;
      CHAR_POW: code = OP_POW;
      default:  code = OP_LPAREN;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] code);
    logic [7:0] ch;
    case (code)
      OP_LPAREN: ch = CHAR_LPAREN;
      OP_ADD:    ch = CHAR_ADD;
      OP_SUB:    ch = CHAR_SUB;
      OP_MUL:    ch = CHAR_MUL;
      OP_DIV:    ch = CHAR_DIV;
      OP_POW:    ch = CHAR_POW;
      default:   ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] op_prec(input logic [2:0] code);
    logic [1:0] prec;
    case (code)
      OP_ADD, OP_SUB: prec = 2'd1;
      OP_MUL, OP_DIV: prec = 2'd2;
      OP_POW:         prec = 2'd3;
      default:        prec = 2'd0;
    endcase
    return prec;
  endfunction

  function automatic char_class_t char_class(input logic [7:0] ch);
    char_class_t cls;
    if (ch >= CHAR_A && ch <= CHAR_Z) begin
      cls = CLS_LETTER;
    end else if (ch == CHAR_LPAREN) begin
      cls = CLS_LPAREN;
    end else if (ch == CHAR_RPAREN) begin
      cls = CLS_RPAREN;
    end else if (op_code(ch) != OP_LPAREN) begin
      cls = CLS_OP;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

[rtl/infix_to_postfix_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from infix characters to postfix characters with a
// closing marker that reports errors and the letters used.
// ----------------------------------------------------------------------------
// Each input request is handled alone. A letter or an ignored character and a
// '(' take the same path. An operator or a ')' reads the top of the operator
// stack again for every operator it pops, because the operator stack is a
// memory with a registered read port. A request with tlast set then pops every
// entry left on the stack, finds the stack empty and sends the marker. Results
// leave through a holding stage and an output register, so a stalled output
// only holds the block when both are full.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // character[7:0]
  input  logic        s_tlast,   // end_of_expression
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // symbol[7:0], error[8], variables_used[34:9], zero
  output logic        m_tuser,   // is_marker
  output logic        m_tlast    // last result of the request
);

  itp_pkg::cmd_t cmd;
  itp_pkg::sts_t sts;
  logic [7:0]    out_symbol;
  logic          out_error;
  logic [25:0]   out_vars;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_character (s_tdata),
    .in_end       (s_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_symbol   (out_symbol),
    .out_marker   (m_tuser),
    .out_error    (out_error),
    .out_vars     (out_vars),
    .out_last     (m_tlast)
  );

  assign m_tdata = {5'd0, out_vars, out_error, out_symbol};

endmodule

[rtl/itp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Controller state machine that sequences the handling of one request through
// the operator stack and the result path.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  itp_pkg::sts_t sts,
  output itp_pkg::cmd_t cmd
);

  itp_pkg::state_t state;
  itp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      itp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = itp_pkg::ST_DISPATCH;
        end
      end
      itp_pkg::ST_DISPATCH: begin
        case (sts.cls)
          itp_pkg::CLS_RPAREN: state_next = itp_pkg::ST_RP_READ;
          itp_pkg::CLS_OP:     state_next = itp_pkg::ST_OP_READ;
          itp_pkg::CLS_LETTER: begin
            if (sts.slot_ok) begin
              state_next = sts.is_end ? itp_pkg::ST_FL_READ : itp_pkg::ST_FINISH;
            end
          end
          default: state_next = sts.is_end ? itp_pkg::ST_FL_READ : itp_pkg::ST_FINISH;
        endcase
      end
      itp_pkg::ST_RP_READ: state_next = itp_pkg::ST_RP_EVAL;
      itp_pkg::ST_RP_EVAL: begin
        if (sts.stack_empty || sts.top_lparen) begin
          state_next = sts.is_end ? itp_pkg::ST_FL_READ : itp_pkg::ST_FINISH;
        end else if (sts.slot_ok) begin
          state_next = itp_pkg::ST_RP_READ;
        end
      end
      itp_pkg::ST_OP_READ: state_next = itp_pkg::ST_OP_EVAL;
      itp_pkg::ST_OP_EVAL: begin
        if (sts.stack_empty || sts.top_lparen || !sts.top_pops) begin
          state_next = sts.is_end ? itp_pkg::ST_FL_READ : itp_pkg::ST_FINISH;
        end else if (sts.slot_ok) begin
          state_next = itp_pkg::ST_OP_READ;
        end
      end
      itp_pkg::ST_FL_READ: state_next = itp_pkg::ST_FL_EVAL;
      itp_pkg::ST_FL_EVAL: begin
        if (sts.stack_empty) begin
          state_next = itp_pkg::ST_MARKER;
        end else if (sts.top_lparen || sts.slot_ok) begin
          state_next = itp_pkg::ST_FL_READ;
        end
      end
      itp_pkg::ST_MARKER: begin
        if (sts.slot_ok) begin
          state_next = itp_pkg::ST_FINISH;
        end
      end
      itp_pkg::ST_FINISH: begin
        if (sts.slot_ok) begin
          state_next = itp_pkg::ST_IDLE;
        end
      end
      default: state_next = itp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.emit    = itp_pkg::EMIT_NONE;
    case (state)
      itp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      itp_pkg::ST_DISPATCH: begin
        case (sts.cls)
          itp_pkg::CLS_LETTER: begin
            if (sts.slot_ok) begin
              cmd.emit = itp_pkg::EMIT_CHAR;
            end
          end
          itp_pkg::CLS_LPAREN: cmd.push = 1'b1;
          default: ;
        endcase
      end
      itp_pkg::ST_RP_EVAL: begin
        if (sts.stack_empty) begin
          cmd.set_err = 1'b1;
        end else if (sts.top_lparen) begin
          cmd.pop = 1'b1;
        end else if (sts.slot_ok) begin
          cmd.pop  = 1'b1;
          cmd.emit = itp_pkg::EMIT_TOP;
        end
      end
      itp_pkg::ST_OP_EVAL: begin
        if (sts.stack_empty || sts.top_lparen || !sts.top_pops) begin
          cmd.push = 1'b1;
        end else if (sts.slot_ok) begin
          cmd.pop  = 1'b1;
          cmd.emit = itp_pkg::EMIT_TOP;
        end
      end
      itp_pkg::ST_FL_EVAL: begin
        if (!sts.stack_empty) begin
          if (sts.top_lparen) begin
            cmd.pop     = 1'b1;
            cmd.set_err = 1'b1;
          end else if (sts.slot_ok) begin
            cmd.pop  = 1'b1;
            cmd.emit = itp_pkg::EMIT_TOP;
          end
        end
      end
      itp_pkg::ST_MARKER: begin
        if (sts.slot_ok) begin
          cmd.emit  = itp_pkg::EMIT_MARKER;
          cmd.clear = 1'b1;
        end
      end
      itp_pkg::ST_FINISH: begin
        cmd.finish = sts.slot_ok;
      end
      default: ;
    endcase
  end

endmodule

[rtl/itp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_datapath
// Operator stack memory, stack count, letter mask, error flag, a one-deep
// holding stage for the newest result and the output register.
// ----------------------------------------------------------------------------
module itp_datapath #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_character,
  input  logic          in_end,
  input  itp_pkg::cmd_t cmd,
  output itp_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_symbol,
  output logic          out_marker,
  output logic          out_error,
  output logic [25:0]   out_vars,
  output logic          out_last
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [2:0]    stack_mem [STACK_DEPTH];
  logic [2:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count;
  logic [25:0]   seen;
  logic          err;
  logic [7:0]    ch;
  logic          is_end;

  logic          pend_valid;
  logic [7:0]    pend_symbol;
  logic          pend_marker;
  logic          pend_error;
  logic [25:0]   pend_vars;

  logic          full;
  logic          slot_ok;
  logic [2:0]    push_code;
  logic [7:0]    new_symbol;
  logic          new_marker;
  logic          new_error;
  logic [25:0]   new_vars;
  logic [7:0]    letter_idx;

  assign full       = (count == CW'(STACK_DEPTH));
  assign rd_addr    = AW'(count - CW'(1));
  assign push_code  = itp_pkg::op_code(ch);
  assign slot_ok    = !pend_valid || !out_valid || out_ready;
  assign letter_idx = ch - itp_pkg::CHAR_A;

  always_comb begin
    sts.cls         = itp_pkg::char_class(ch);
    sts.is_end      = is_end;
    sts.stack_empty = (count == '0);
    sts.top_lparen  = (rd_data == itp_pkg::OP_LPAREN);
    sts.top_pops    = (itp_pkg::op_prec(push_code) <= itp_pkg::op_prec(rd_data));
    sts.slot_ok     = slot_ok;
  end

  always_comb begin
    new_symbol = 8'd0;
    new_marker = 1'b0;
    new_error  = 1'b0;
    new_vars   = '0;
    case (cmd.emit)
      itp_pkg::EMIT_CHAR: new_symbol = ch;
      itp_pkg::EMIT_TOP:  new_symbol = itp_pkg::op_char(rd_data);
      itp_pkg::EMIT_MARKER: begin
        new_marker = 1'b1;
        new_error  = err;
        new_vars   = seen;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      stack_mem[count[AW-1:0]] <= push_code;
    end
    rd_data <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch     <= in_character;
      is_end <= in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seen  <= '0;
      err   <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      seen  <= '0;
      err   <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (full) begin
          err <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.pop) begin
        count <= count - CW'(1);
      end
      if (cmd.set_err) begin
        err <= 1'b1;
      end
      if (cmd.emit == itp_pkg::EMIT_CHAR) begin
        seen <= seen | (26'd1 << letter_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit != itp_pkg::EMIT_NONE) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.emit != itp_pkg::EMIT_NONE || cmd.finish) && pend_valid) begin
      out_symbol <= pend_symbol;
      out_marker <= pend_marker;
      out_error  <= pend_error;
      out_vars   <= pend_vars;
      out_last   <= cmd.finish;
    end
    if (cmd.emit != itp_pkg::EMIT_NONE) begin
      pend_symbol <= new_symbol;
      pend_marker <= new_marker;
      pend_error  <= new_error;
      pend_vars   <= new_vars;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("Stack count exceeds the stack depth.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("Pop issued on an empty stack.");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != itp_pkg::EMIT_NONE || cmd.finish) |-> slot_ok)
    else $error("Result moved while the output register was blocked.");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (count == '0 && seen == '0 && !err))
    else $error("State not cleared after the end marker.");

endmodule
